// File: hw/rtl/tccw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, codes and interface types of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int MOVE_W = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT + 2);
  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int CELL_W = 16;

  // port widths
  localparam int FUNC_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int RD_ROW_W   = 5;
  localparam int RD_COL_W   = 7;
  localparam int CUR_ROW_W  = 5;
  localparam int CUR_COL_W  = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h0f;
  localparam logic [BYTE_W-1:0] CR_CODE    = 8'd13;
  localparam logic [BYTE_W-1:0] LF_CODE    = 8'd10;

  localparam logic [FUNC_W-1:0] FUNC_WRITE      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SHIFT_UP   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SHIFT_DOWN = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ       = 3'd4;

  // register index is paddr[2]
  localparam logic REG_SCROLL_ENABLE  = 1'b0;
  localparam logic REG_TEXT_ATTRIBUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_PUT,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_DONE,
    RET_PUT
  } ret_t;

  typedef struct packed {
    logic              go;
    logic              dir_up;
    logic [MOVE_W-1:0] moved;
    logic [BYTE_W-1:0] attr;
  } sweep_cmd_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/text_console_cell_writer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// Text console engine: cell memory, cursor, character writes with wrap and
// scroll, clear, multi-line shifts and cell read-back.
//
//   channel   handshake                 payload
//   command   start / busy              func char_code line_count read_row
//                                       read_column
//   result    done (one-cycle strobe)   cell_char cell_attribute cursor_row
//                                       cursor_column
//   config    psel penable pwrite       paddr pwdata prdata (pready tied high)
//
// A cell read goes through one registered memory read.
// Clear and shift walk the cell memory one cell per cycle, set by the single
// write port. A scrolling write walks the same way and then places its
// character. A zero shift does not walk the memory.
// After reset busy stays high while the memory is filled with blanks;
// register writes are taken throughout.
// Results are never held off; busy is low again in the strobe cycle.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tccw_pkg::FUNC_W-1:0]     func,
  input  wire logic [tccw_pkg::BYTE_W-1:0]     char_code,
  input  wire logic [tccw_pkg::BYTE_W-1:0]     line_count,
  input  wire logic [tccw_pkg::RD_ROW_W-1:0]   read_row,
  input  wire logic [tccw_pkg::RD_COL_W-1:0]   read_column,
  output logic                                 done,
  output logic      [tccw_pkg::BYTE_W-1:0]     cell_char,
  output logic      [tccw_pkg::BYTE_W-1:0]     cell_attribute,
  output logic      [tccw_pkg::CUR_ROW_W-1:0]  cursor_row,
  output logic      [tccw_pkg::CUR_COL_W-1:0]  cursor_column,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tccw_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [tccw_pkg::PDATA_W-1:0]    pwdata,
  output logic      [tccw_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready
);
  import tccw_pkg::*;

  state_t            state, state_next;
  ret_t              ret_q, ret_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic              done_next;
  logic [BYTE_W-1:0] out_char, out_char_next;
  logic [BYTE_W-1:0] out_attr, out_attr_next;

  logic [FUNC_W-1:0]   func_q;
  logic [BYTE_W-1:0]   code_q;
  logic [BYTE_W-1:0]   count_q;
  logic [RD_ROW_W-1:0] row_q;
  logic [RD_COL_W-1:0] col_q;

  logic              scroll_enable;
  logic [BYTE_W-1:0] text_attr;

  sweep_cmd_t        sw_cmd;
  mem_req_t          sw_req;
  logic              sw_busy;
  logic [CELL_W-1:0] rd_data;

  logic              cw_en;
  logic [ADDR_W-1:0] cw_addr;
  logic              rq_en;
  logic [ADDR_W-1:0] rq_addr;

  logic              accept;
  logic              cfg_wr;

  // character step operands and results
  logic              wrap;
  logic [ROW_W-1:0]  row_a;
  logic [COL_W-1:0]  col_a;
  logic              overflow;
  logic [ROW_W-1:0]  step_row;
  logic [COL_W-1:0]  step_col;
  logic [ROW_W-1:0]  step_row_out;
  logic [COL_W-1:0]  step_col_out;
  logic              step_store;
  logic [ADDR_W-1:0] step_addr;

  logic              read_in_range;
  logic [ROW_W-1:0]  lines;
  logic [MOVE_W-1:0] moved_lines;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_SCROLL_ENABLE:  prdata = PDATA_W'(scroll_enable);
      REG_TEXT_ATTRIBUTE: prdata = PDATA_W'(text_attr);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_enable <= 1'b0;
      text_attr     <= RESET_ATTR;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SCROLL_ENABLE) begin
        scroll_enable <= pwdata[0];
      end else begin
        text_attr <= pwdata[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func;
      code_q  <= char_code;
      count_q <= line_count;
      row_q   <= read_row;
      col_q   <= read_column;
    end
    out_char <= out_char_next;
    out_attr <= out_attr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      ret_q   <= RET_IDLE;
      cur_row <= '0;
      cur_col <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      ret_q   <= ret_next;
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      done    <= done_next;
    end
  end

  // wrap, overflow and the character step itself
  always_comb begin
    wrap     = cur_col >= COL_W'(SCREEN_WIDTH);
    col_a    = wrap ? '0 : cur_col;
    row_a    = wrap ? cur_row + 1'b1 : cur_row;
    overflow = row_a >= ROW_W'(SCREEN_HEIGHT);

    if (state == ST_PUT) begin
      step_row = cur_row;
      step_col = cur_col;
    end else begin
      step_row = overflow ? '0 : row_a;
      step_col = col_a;
    end

    step_store   = 1'b0;
    step_row_out = step_row;
    step_col_out = step_col;
    if (code_q == CR_CODE) begin
      step_col_out = '0;
    end else if (code_q == LF_CODE) begin
      step_row_out = step_row + 1'b1;
    end else begin
      step_store   = 1'b1;
      step_col_out = step_col + 1'b1;
    end
    step_addr = ADDR_W'(32'(step_row) * 32'(SCREEN_WIDTH) + 32'(step_col));

    read_in_range = (32'(row_q) < 32'(SCREEN_HEIGHT)) &&
                    (32'(col_q) < 32'(SCREEN_WIDTH));
    rq_addr = ADDR_W'(32'(row_q) * 32'(SCREEN_WIDTH) + 32'(col_q));

    lines = (32'(count_q) > 32'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT)
                                                 : ROW_W'(count_q);
    moved_lines = MOVE_W'(32'(lines) * 32'(SCREEN_WIDTH));
  end

  always_comb begin
    state_next    = state;
    ret_next      = ret_q;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    done_next     = 1'b0;
    out_char_next = '0;
    out_attr_next = '0;
    sw_cmd.go     = 1'b0;
    sw_cmd.dir_up = 1'b1;
    sw_cmd.moved  = MOVE_W'(CELL_COUNT);
    sw_cmd.attr   = text_attr;
    cw_en         = 1'b0;
    cw_addr       = step_addr;
    rq_en         = 1'b0;
    busy          = 1'b1;

    case (state)
      ST_INIT: begin
        sw_cmd.go   = 1'b1;
        sw_cmd.attr = RESET_ATTR;
        ret_next    = RET_IDLE;
        state_next  = ST_SWEEP;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (func_q)
          FUNC_WRITE: begin
            if (overflow && scroll_enable) begin
              cur_row_next = ROW_W'(SCREEN_HEIGHT - 1);
              cur_col_next = col_a;
              sw_cmd.go    = 1'b1;
              sw_cmd.moved = MOVE_W'(SCREEN_WIDTH);
              ret_next     = RET_PUT;
              state_next   = ST_SWEEP;
            end else begin
              cw_en        = step_store;
              cur_row_next = step_row_out;
              cur_col_next = step_col_out;
              done_next    = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          FUNC_CLEAR: begin
            sw_cmd.go  = 1'b1;
            ret_next   = RET_DONE;
            state_next = ST_SWEEP;
          end
          FUNC_SHIFT_UP, FUNC_SHIFT_DOWN: begin
            if (lines == '0) begin
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              sw_cmd.go     = 1'b1;
              sw_cmd.dir_up = (func_q == FUNC_SHIFT_UP);
              sw_cmd.moved  = moved_lines;
              ret_next      = RET_DONE;
              state_next    = ST_SWEEP;
            end
          end
          FUNC_READ: begin
            if (read_in_range) begin
              rq_en      = 1'b1;
              state_next = ST_READ;
            end else begin
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SWEEP: begin
        if (!sw_busy) begin
          case (ret_q)
            RET_DONE: begin
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end
            RET_PUT: begin
              state_next = ST_PUT;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_PUT: begin
        cw_en        = step_store;
        cur_row_next = step_row_out;
        cur_col_next = step_col_out;
        done_next    = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_READ: begin
        out_char_next = rd_data[CELL_W-1:BYTE_W];
        out_attr_next = rd_data[BYTE_W-1:0];
        done_next     = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  tccw_sweep u_sweep (
    .clk     (clk),
    .rst     (rst),
    .cmd     (sw_cmd),
    .rd_data (rd_data),
    .req     (sw_req),
    .busy    (sw_busy)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk     (clk),
    .wr_en   (sw_req.wr_en || cw_en),
    .wr_addr (sw_req.wr_en ? sw_req.wr_addr : cw_addr),
    .wr_data (sw_req.wr_en ? sw_req.wr_data : {code_q, text_attr}),
    .rd_en   (sw_req.rd_en || rq_en),
    .rd_addr (sw_req.rd_en ? sw_req.rd_addr : rq_addr),
    .rd_data (rd_data)
  );

  assign cell_char      = out_char;
  assign cell_attribute = out_attr;
  assign cursor_row     = CUR_ROW_W'(cur_row);
  assign cursor_column  = CUR_COL_W'(cur_col);

endmodule
`default_nettype wire

// File: hw/rtl/tccw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tccw_sweep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccw_sweep
// Whole-screen walker: copies every cell from a source offset by a number of
// cells up or down, or fills it with a blank, one cell per cycle.
// ----------------------------------------------------------------------------
module tccw_sweep (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tccw_pkg::sweep_cmd_t       cmd,
  input  wire logic [tccw_pkg::CELL_W-1:0] rd_data,
  output tccw_pkg::mem_req_t              req,
  output logic                            busy
);
  import tccw_pkg::*;

  localparam int SUM_W = MOVE_W + 1;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CELL_COUNT - 1);

  logic              active;
  logic              dir_up;
  logic [MOVE_W-1:0] moved;
  logic [BYTE_W-1:0] attr;
  logic [ADDR_W-1:0] d;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_blank;

  logic [SUM_W-1:0]  src_up;
  logic [MOVE_W-1:0] src_down;
  logic              src_valid;
  logic              last;

  always_comb begin
    src_up    = SUM_W'(d) + SUM_W'(moved);
    src_down  = MOVE_W'(d) - moved;
    src_valid = dir_up ? (src_up < SUM_W'(CELL_COUNT)) : (MOVE_W'(d) >= moved);
    last      = dir_up ? (d == LAST) : (d == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      if (cmd.go) begin
        active <= 1'b1;
      end else if (active && last) begin
        active <= 1'b0;
      end
      wr_pend <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      dir_up <= cmd.dir_up;
      moved  <= cmd.moved;
      attr   <= cmd.attr;
      d      <= cmd.dir_up ? '0 : LAST;
    end else if (active) begin
      d <= dir_up ? d + 1'b1 : d - 1'b1;
    end
    wr_addr  <= d;
    wr_blank <= !src_valid;
  end

  always_comb begin
    req.rd_en   = active && src_valid;
    req.rd_addr = dir_up ? ADDR_W'(src_up) : ADDR_W'(src_down);
    req.wr_en   = wr_pend;
    req.wr_addr = wr_addr;
    req.wr_data = wr_blank ? {BLANK_CHAR, attr} : rd_data;
    busy        = active || wr_pend;
  end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console cell writer. A shadow screen and
// cursor predict every reply; directed tests cover reset contents, register
// access, character edge codes, clear and shifts. Long random text streams
// with line endings, read-backs and walks run under four register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tccw_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
  localparam int STALL_LIMIT = 12000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [BYTE_W-1:0]    ch;
    logic [BYTE_W-1:0]    attr;
    logic [CUR_ROW_W-1:0] row;
    logic [CUR_COL_W-1:0] col;
  } console_reply_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [FUNC_W-1:0]    func;
  logic [BYTE_W-1:0]    char_code;
  logic [BYTE_W-1:0]    line_count;
  logic [RD_ROW_W-1:0]  read_row;
  logic [RD_COL_W-1:0]  read_column;
  logic                 done;
  logic [BYTE_W-1:0]    cell_char;
  logic [BYTE_W-1:0]    cell_attribute;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic [CUR_COL_W-1:0] cursor_column;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // shadow screen and cursor
  logic [BYTE_W-1:0] shadow_char [CELL_COUNT];
  logic [BYTE_W-1:0] shadow_attr [CELL_COUNT];
  int unsigned       shadow_row;
  int unsigned       shadow_col;
  logic              scroll_shadow;
  logic [BYTE_W-1:0] attr_shadow;

  console_reply_t expected_replies[$];
  console_reply_t front_reply;

  int error_count = 0;
  int stall_cycles = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_reads = 0;
  int n_walks = 0;
  int n_spare = 0;
  int n_scroll_ups = 0;
  int n_top_returns = 0;
  int n_line_wraps = 0;

  text_console_cell_writer_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .char_code(char_code), .line_count(line_count),
    .read_row(read_row), .read_column(read_column),
    .done(done), .cell_char(cell_char), .cell_attribute(cell_attribute),
    .cursor_row(cursor_row), .cursor_column(cursor_column),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void blank_cells(input int first, input int count);
    for (int i = 0; i < count && first + i < CELL_COUNT; i++) begin
      shadow_char[first + i] = BLANK_CHAR;
      shadow_attr[first + i] = attr_shadow;
    end
  endfunction

  function automatic void move_lines(input bit up, input int lines);
    int moved;
    if (lines > SCREEN_HEIGHT) lines = SCREEN_HEIGHT;
    moved = lines * SCREEN_WIDTH;
    if (moved == 0) return;
    if (up) begin
      for (int i = 0; i < CELL_COUNT - moved; i++) begin
        shadow_char[i] = shadow_char[i + moved];
        shadow_attr[i] = shadow_attr[i + moved];
      end
      blank_cells(CELL_COUNT - moved, moved);
    end else begin
      for (int i = CELL_COUNT - 1; i >= moved; i--) begin
        shadow_char[i] = shadow_char[i - moved];
        shadow_attr[i] = shadow_attr[i - moved];
      end
      blank_cells(0, moved);
    end
  endfunction

  function automatic console_reply_t predict_console_op(
    input logic [FUNC_W-1:0]   f,
    input logic [BYTE_W-1:0]   code,
    input logic [BYTE_W-1:0]   count,
    input logic [RD_ROW_W-1:0] row,
    input logic [RD_COL_W-1:0] col
  );
    console_reply_t r;
    int pos;
    r = '0;
    case (f)
      FUNC_WRITE: begin
        n_writes++;
        if (shadow_col >= SCREEN_WIDTH) begin
          shadow_col = 0;
          shadow_row++;
          n_line_wraps++;
        end
        if (shadow_row >= SCREEN_HEIGHT) begin
          if (scroll_shadow) begin
            shadow_row = SCREEN_HEIGHT - 1;
            move_lines(1'b1, 1);
            n_scroll_ups++;
          end else begin
            shadow_row = 0;
            n_top_returns++;
          end
        end
        if (code == CR_CODE) begin
          shadow_col = 0;
        end else if (code == LF_CODE) begin
          shadow_row++;
        end else begin
          pos = shadow_row * SCREEN_WIDTH + shadow_col;
          if (pos < CELL_COUNT) begin
            shadow_char[pos] = code;
            shadow_attr[pos] = attr_shadow;
          end
          shadow_col++;
        end
      end
      FUNC_CLEAR: begin
        n_walks++;
        blank_cells(0, CELL_COUNT);
      end
      FUNC_SHIFT_UP: begin
        n_walks++;
        move_lines(1'b1, int'(count));
      end
      FUNC_SHIFT_DOWN: begin
        n_walks++;
        move_lines(1'b0, int'(count));
      end
      FUNC_READ: begin
        n_reads++;
        if (row < SCREEN_HEIGHT && col < SCREEN_WIDTH) begin
          r.ch   = shadow_char[row * SCREEN_WIDTH + col];
          r.attr = shadow_attr[row * SCREEN_WIDTH + col];
        end
      end
      default: n_spare++;
    endcase
    r.row = CUR_ROW_W'(shadow_row);
    r.col = CUR_COL_W'(shadow_col);
    return r;
  endfunction

  task automatic issue_command(
    input logic [FUNC_W-1:0]   f,
    input logic [BYTE_W-1:0]   code,
    input logic [BYTE_W-1:0]   count,
    input logic [RD_ROW_W-1:0] row,
    input logic [RD_COL_W-1:0] col
  );
    @(negedge clk);
    start       <= 1'b1;
    func        <= f;
    char_code   <= code;
    line_count  <= count;
    read_row    <= row;
    read_column <= col;
    do @(posedge clk); while (busy !== 1'b0);
    expected_replies.push_back(predict_console_op(f, code, count, row, col));
  endtask

  task automatic hold_sender(input int cycles);
    if (cycles == 0) return;
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [PDATA_W-1:0] value);
    wait_for_quiet();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SCROLL_ENABLE) scroll_shadow = value[0];
    else attr_shadow = value[BYTE_W-1:0];
  endtask

  task automatic check_register(input logic idx, input logic [PDATA_W-1:0] want);
    wait_for_quiet();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read %08h want %08h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: cursor %0d,%0d",
                                  cursor_row, cursor_column));
      end else begin
        front_reply = expected_replies.pop_front();
        n_checked++;
        if (cell_char !== front_reply.ch)
          report_mismatch($sformatf("cell_char %02h want %02h", cell_char, front_reply.ch));
        if (cell_attribute !== front_reply.attr)
          report_mismatch($sformatf("cell_attribute %02h want %02h",
                                    cell_attribute, front_reply.attr));
        if (cursor_row !== front_reply.row)
          report_mismatch($sformatf("cursor_row %0d want %0d", cursor_row, front_reply.row));
        if (cursor_column !== front_reply.col)
          report_mismatch($sformatf("cursor_column %0d want %0d",
                                    cursor_column, front_reply.col));
      end
    end
  end

  // watchdog on transactions
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_power_on_contents();
    issue_command(FUNC_READ, BYTE_W'($urandom), BYTE_W'($urandom), 5'd0, 7'd0);
    issue_command(FUNC_READ, BYTE_W'($urandom), BYTE_W'($urandom), 5'd24, 7'd79);
    issue_command(FUNC_READ, BYTE_W'($urandom), BYTE_W'($urandom), 5'd12, 7'd40);
    issue_command(FUNC_READ, BYTE_W'($urandom), BYTE_W'($urandom), 5'd25, 7'd0);
    issue_command(FUNC_READ, BYTE_W'($urandom), BYTE_W'($urandom), 5'd0, 7'd80);
    issue_command(FUNC_READ, BYTE_W'($urandom), BYTE_W'($urandom), 5'd31, 7'd127);
  endtask

  task automatic test_register_access();
    logic [PDATA_W-1:0] v;
    check_register(REG_SCROLL_ENABLE, '0);
    check_register(REG_TEXT_ATTRIBUTE, PDATA_W'(RESET_ATTR));
    v = $urandom;
    v[7:0] = 8'ha5;
    write_register(REG_TEXT_ATTRIBUTE, v);
    check_register(REG_TEXT_ATTRIBUTE, 32'h0000_00a5);
    v = $urandom;
    v[0] = 1'b1;
    write_register(REG_SCROLL_ENABLE, v);
    check_register(REG_SCROLL_ENABLE, 32'd1);
    v = ~v;
    v[0] = 1'b0;
    write_register(REG_SCROLL_ENABLE, v);
    check_register(REG_SCROLL_ENABLE, 32'd0);
  endtask

  task automatic test_char_edges();
    logic [BYTE_W-1:0]   n;
    logic [RD_ROW_W-1:0] r;
    logic [RD_COL_W-1:0] c;
    n = BYTE_W'($urandom);
    r = RD_ROW_W'($urandom);
    c = RD_COL_W'($urandom);
    issue_command(FUNC_WRITE, 8'h00, n, r, c);
    issue_command(FUNC_WRITE, 8'hff, n, r, c);
    issue_command(FUNC_WRITE, CR_CODE, n, r, c);
    issue_command(FUNC_WRITE, LF_CODE, n, r, c);
    issue_command(FUNC_WRITE, BLANK_CHAR, n, r, c);
    issue_command(FUNC_WRITE, 8'h7f, n, r, c);
    issue_command(FUNC_READ, BYTE_W'($urandom), n, 5'd0, 7'd0);
    issue_command(FUNC_READ, BYTE_W'($urandom), n, 5'd0, 7'd1);
    issue_command(FUNC_READ, BYTE_W'($urandom), n, 5'd1, 7'd1);
    issue_command(FUNC_SPARE_FIRST, BYTE_W'($urandom), n, r, c);
    issue_command(FUNC_SPARE_FIRST + 3'd1, BYTE_W'($urandom), n, r, c);
    issue_command(FUNC_SPARE_LAST, BYTE_W'($urandom), n, r, c);
  endtask

  task automatic test_clear_and_shift();
    logic [BYTE_W-1:0]   n;
    logic [RD_ROW_W-1:0] r;
    logic [RD_COL_W-1:0] c;
    n = BYTE_W'($urandom);
    r = RD_ROW_W'($urandom);
    c = RD_COL_W'($urandom);
    issue_command(FUNC_SHIFT_DOWN, n, 8'd1, r, c);
    issue_command(FUNC_READ, n, BYTE_W'($urandom), 5'd1, 7'd0);
    issue_command(FUNC_READ, n, BYTE_W'($urandom), 5'd0, 7'd0);
    issue_command(FUNC_SHIFT_UP, n, 8'd1, r, c);
    issue_command(FUNC_SHIFT_UP, n, 8'd0, r, c);
    issue_command(FUNC_SHIFT_DOWN, n, 8'd0, r, c);
    issue_command(FUNC_READ, n, BYTE_W'($urandom), 5'd0, 7'd1);
    issue_command(FUNC_SHIFT_DOWN, n, 8'd255, r, c);
    issue_command(FUNC_READ, n, BYTE_W'($urandom), 5'd24, 7'd79);
    issue_command(FUNC_WRITE, 8'h41, BYTE_W'($urandom), r, c);
    issue_command(FUNC_CLEAR, n, BYTE_W'($urandom), r, c);
    issue_command(FUNC_READ, n, BYTE_W'($urandom), 5'd1, 7'd1);
  endtask

  task automatic test_text_stream(input int n_items, input logic scroll,
                                  input logic [BYTE_W-1:0] attr);
    logic [PDATA_W-1:0]  v;
    logic [FUNC_W-1:0]   f;
    logic [BYTE_W-1:0]   code;
    logic [BYTE_W-1:0]   count;
    logic [RD_ROW_W-1:0] row;
    logic [RD_COL_W-1:0] col;
    logic [BYTE_W-1:0]   line_end[$];
    int                  line_left;
    int                  burst_left;
    int                  pick;
    v = $urandom;
    v[0] = scroll;
    write_register(REG_SCROLL_ENABLE, v);
    v = $urandom;
    v[7:0] = attr;
    write_register(REG_TEXT_ATTRIBUTE, v);
    line_left = $urandom_range(0, 79);
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_for_quiet();
      if (burst_left == 0) begin
        hold_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      f = FUNC_WRITE;
      code = BYTE_W'($urandom);
      count = BYTE_W'($urandom);
      row = RD_ROW_W'($urandom);
      col = RD_COL_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if (line_end.size() == 0 && line_left == 0) begin
          case ($urandom_range(0, 3))
            0, 1: line_end = '{CR_CODE, LF_CODE};
            2: line_end = '{LF_CODE};
            default: line_end = '{CR_CODE};
          endcase
          line_left = ($urandom_range(0, 7) == 0) ? $urandom_range(81, 200)
                                                  : $urandom_range(0, 79);
        end
        if (line_end.size() != 0) code = line_end.pop_front();
        else line_left--;
      end else if (pick < 92) begin
        f = FUNC_READ;
        if ($urandom_range(0, 4) != 0) begin
          row = ($urandom_range(0, 1) != 0) ? RD_ROW_W'(shadow_row)
                                            : RD_ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
          col = RD_COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
        end
      end else if (pick < 96) begin
        f = (pick < 94) ? FUNC_SHIFT_UP : FUNC_SHIFT_DOWN;
        case ($urandom_range(0, 5))
          0: count = 8'd0;
          1: count = BYTE_W'($urandom_range(1, 3));
          2: count = BYTE_W'($urandom_range(SCREEN_HEIGHT - 1, SCREEN_HEIGHT + 1));
          default: ;
        endcase
      end else if (pick < 97) begin
        f = FUNC_CLEAR;
      end else begin
        f = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      end
      issue_command(f, code, count, row, col);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_WRITE;
    char_code = '0;
    line_count = '0;
    read_row = '0;
    read_column = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    scroll_shadow = 1'b0;
    attr_shadow = RESET_ATTR;
    shadow_row = 0;
    shadow_col = 0;
    blank_cells(0, CELL_COUNT);
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_power_on_contents();
    test_register_access();
    test_char_edges();
    test_clear_and_shift();
    test_text_stream(450, 1'b0, RESET_ATTR);
    test_text_stream(450, 1'b1, 8'h00);
    test_text_stream(450, 1'b1, 8'hff);
    test_text_stream(450, 1'b0, BYTE_W'($urandom));

    wait_for_quiet();
    repeat (8) @(posedge clk);
    $display("Covered %0d writes, %0d reads, %0d clears/shifts, %0d spare codes; %0d checked.",
             n_writes, n_reads, n_walks, n_spare, n_checked);
    $display("Cursor took %0d line wraps, %0d scroll-ups and %0d returns to the top row.",
             n_line_wraps, n_scroll_ups, n_top_returns);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
